// ----- rtl/assert_macros.svh -----
// assertion macros shared by the line rasterizer rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define LRBF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lrbf assertion failed");
// condition must never be seen at a rising clock edge out of reset
`define LRBF_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("lrbf forbidden condition seen");
`else
`define LRBF_ASSERT(lbl, clk, rst_n, prop)
`define LRBF_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/lrbf_pkg.sv -----
// shared types, constants and helpers for the banked framebuffer line rasterizer
// no dependencies; used by lrbf_engine and line_raster_banked_fb_core
`default_nettype none

package lrbf_pkg;

	// field widths
	localparam int COORD_W  = 12;
	localparam int COLOR_W  = 16;
	localparam int BANK_W   = 5;
	localparam int OFFSET_W = 15;
	localparam int STEPS_W  = 12;
	localparam int DEC_W    = 15;
	localparam int MINOR2_W = 13;

	// linear address is y * 1024 + x
	localparam int ROW_SHIFT = 10;
	localparam int ADDR_W    = 2 * ROW_SHIFT;

	// default screen geometry and bank size
	localparam int DEF_SCREEN_WIDTH  = 1024;
	localparam int DEF_SCREEN_HEIGHT = 768;
	localparam int DEF_BANK_SHIFT    = 15;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	// one input item
	typedef struct packed {
		op_t                 op;
		coord_t              x_start;
		coord_t              y_start;
		coord_t              x_end;
		coord_t              y_end;
		logic [COLOR_W-1:0]  pen_color;
	} item_t;

	// one result item
	typedef struct packed {
		coord_t              pixel_x;
		coord_t              pixel_y;
		logic                visible;
		logic [BANK_W-1:0]   bank;
		logic [OFFSET_W-1:0] bank_offset;
		logic                bank_switch;
		logic [COLOR_W-1:0]  write_color;
		logic                last_pixel;
	} pixel_t;

	// absolute difference of two signed coordinates, always fits the coordinate width
	function automatic logic [COORD_W-1:0] abs_diff(input coord_t a, input coord_t b);
		logic [COORD_W:0] d;
		logic [COORD_W:0] n;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		n = '0 - d;
		return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
	endfunction

	function automatic coord_t min_coord(input coord_t a, input coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic greater(input coord_t a, input coord_t b);
		return a > b;
	endfunction

	// move a coordinate by a direction of -1, 0 or +1
	function automatic coord_t add_dir(input coord_t c, input logic signed [1:0] d);
		logic [COORD_W-1:0] ext;
		ext = {{(COORD_W-2){d[1]}}, d};
		return c + ext;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/line_raster_banked_fb_core.sv -----
// top level of the bresenham line rasterizer for a banked 16-bit framebuffer
// depends on lrbf_pkg, lrbf_engine and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// A start item (op = 0) loads both endpoints and the color and returns the first
// pixel; each step item (op = 1) returns the next pixel until last_pixel is seen.
// A step with no line active returns nothing. Every pixel comes with its clip flag,
// and visible pixels with the bank and offset of the word address y*1024 + x and a
// bank_switch flag when the bank differs from the last one switched to (the first
// visible pixel after reset always switches). One item is taken per clock while the
// input side is not stalled, and its result goes through the input register, then
// the combinational decision add-compare and address split into the result
// register. The input side stalls only while the result register holds an item
// that the output side is stalling.

module line_raster_banked_fb_core #(
	parameter int SCREEN_WIDTH  = lrbf_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = lrbf_pkg::DEF_SCREEN_HEIGHT,
	parameter int BANK_SHIFT    = lrbf_pkg::DEF_BANK_SHIFT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              op,
	input  wire logic signed [lrbf_pkg::COORD_W-1:0] x_start,
	input  wire logic signed [lrbf_pkg::COORD_W-1:0] y_start,
	input  wire logic signed [lrbf_pkg::COORD_W-1:0] x_end,
	input  wire logic signed [lrbf_pkg::COORD_W-1:0] y_end,
	input  wire logic [lrbf_pkg::COLOR_W-1:0]      pen_color,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [lrbf_pkg::COORD_W-1:0]    pixel_x,
	output logic signed [lrbf_pkg::COORD_W-1:0]    pixel_y,
	output logic                                   visible,
	output logic [lrbf_pkg::BANK_W-1:0]            bank,
	output logic [lrbf_pkg::OFFSET_W-1:0]          bank_offset,
	output logic                                   bank_switch,
	output logic [lrbf_pkg::COLOR_W-1:0]           write_color,
	output logic                                   last_pixel
);

	lrbf_pkg::item_t  item_s1;
	logic             valid_s1;
	lrbf_pkg::pixel_t out_q;
	logic             out_valid_q;
	logic             advance;
	logic             fire;
	logic             has_result;
	lrbf_pkg::pixel_t pix;

	// handshake control
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.op        <= lrbf_pkg::op_t'(op);
			item_s1.x_start   <= x_start;
			item_s1.y_start   <= y_start;
			item_s1.x_end     <= x_end;
			item_s1.y_end     <= y_end;
			item_s1.pen_color <= pen_color;
		end
	end

	lrbf_engine #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.BANK_SHIFT    (BANK_SHIFT)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.has_result (has_result),
		.pix        (pix)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			out_q <= pix;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = out_q.pixel_x;
	assign pixel_y     = out_q.pixel_y;
	assign visible     = out_q.visible;
	assign bank        = out_q.bank;
	assign bank_offset = out_q.bank_offset;
	assign bank_switch = out_q.bank_switch;
	assign write_color = out_q.write_color;
	assign last_pixel  = out_q.last_pixel;

	`LRBF_ASSERT(a_out_from_item, clk, arst_n, $rose(out_valid_q) |-> $past(valid_s1))
	`LRBF_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> (out_valid_q && out_stall))
	`LRBF_ASSERT(a_held_item, clk, arst_n, (valid_s1 && in_stall) |=> (valid_s1 && $stable(item_s1)))

endmodule

`default_nettype wire

// ----- rtl/lrbf_engine.sv -----
// bresenham line state, pixel clipping and bank address split for one item per cycle while fire is high
// depends on lrbf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lrbf_engine #(
	parameter int SCREEN_WIDTH  = lrbf_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = lrbf_pkg::DEF_SCREEN_HEIGHT,
	parameter int BANK_SHIFT    = lrbf_pkg::DEF_BANK_SHIFT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire lrbf_pkg::item_t item,
	output logic                 has_result,
	output lrbf_pkg::pixel_t     pix
);

	localparam int CW = lrbf_pkg::COORD_W;
	localparam int DW = lrbf_pkg::DEC_W;
	localparam int MW = lrbf_pkg::MINOR2_W;
	localparam int SW = lrbf_pkg::STEPS_W;
	localparam int RS = lrbf_pkg::ROW_SHIFT;
	localparam int AW = lrbf_pkg::ADDR_W;
	localparam logic [CW-1:0] WIDTH_LIM  = CW'(SCREEN_WIDTH);
	localparam logic [CW-1:0] HEIGHT_LIM = CW'(SCREEN_HEIGHT);
	localparam logic [AW-1:0] OFF_MASK   = AW'((1 << BANK_SHIFT) - 1);
	localparam logic signed [DW-1:0] DEC_BOUND = DW'(2 * ((1 << CW) - 1));

	// line state
	lrbf_pkg::coord_t            x_q, y_q;
	logic signed [DW-1:0]        dec_q;
	logic [MW-1:0]               minor2_q;
	logic signed [DW-1:0]        diag_q;
	logic [SW-1:0]               steps_q;
	logic signed [1:0]           xdir_q, ydir_q;
	logic                        xmaj_q;
	logic [lrbf_pkg::COLOR_W-1:0] color_q;
	logic                        busy_q;
	logic [lrbf_pkg::BANK_W-1:0] last_bank_q;
	logic                        bank_known_q;

	// start: extents, major axis and first point
	logic [CW-1:0]               dx, dy, major, minor;
	logic                        st_xmaj;
	lrbf_pkg::coord_t            st_x, st_y;
	logic signed [1:0]           st_xdir, st_ydir;
	logic signed [DW-1:0]        st_dec, st_diag;

	always_comb begin
		dx      = lrbf_pkg::abs_diff(item.x_start, item.x_end);
		dy      = lrbf_pkg::abs_diff(item.y_start, item.y_end);
		st_xmaj = dx >= dy;
		major   = st_xmaj ? dx : dy;
		minor   = st_xmaj ? dy : dx;
		st_dec  = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
		st_diag = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
		if (item.x_start == item.x_end) begin
			st_x    = item.x_start;
			st_y    = lrbf_pkg::min_coord(item.y_start, item.y_end);
			st_xdir = 2'sd0;
			st_ydir = 2'sd1;
		end else if (item.y_start == item.y_end) begin
			st_x    = lrbf_pkg::min_coord(item.x_start, item.x_end);
			st_y    = item.y_start;
			st_xdir = 2'sd1;
			st_ydir = 2'sd0;
		end else begin
			st_x    = item.x_start;
			st_y    = item.y_start;
			st_xdir = lrbf_pkg::greater(item.x_end, item.x_start) ? 2'sd1 : -2'sd1;
			st_ydir = lrbf_pkg::greater(item.y_end, item.y_start) ? 2'sd1 : -2'sd1;
		end
	end

	// step: one decision update and one move along each axis that advances
	logic                        take_minor;
	logic signed [DW-1:0]        sp_dec;
	lrbf_pkg::coord_t            sp_x, sp_y, x_adv, y_adv;

	always_comb begin
		take_minor = !dec_q[DW-1] && (dec_q != '0);
		sp_dec     = take_minor ? (dec_q + diag_q)
		                        : (dec_q + $signed({{(DW-MW){1'b0}}, minor2_q}));
		x_adv      = lrbf_pkg::add_dir(x_q, xdir_q);
		y_adv      = lrbf_pkg::add_dir(y_q, ydir_q);
		sp_x       = (xmaj_q || take_minor) ? x_adv : x_q;
		sp_y       = (!xmaj_q || take_minor) ? y_adv : y_q;
	end

	// select the pixel this item produces
	logic                        is_start;
	lrbf_pkg::coord_t            nx, ny;
	logic [SW-1:0]               n_steps;
	logic [lrbf_pkg::COLOR_W-1:0] n_color;

	always_comb begin
		is_start   = item.op == lrbf_pkg::OP_START;
		has_result = is_start || busy_q;
		nx         = is_start ? st_x : sp_x;
		ny         = is_start ? st_y : sp_y;
		n_steps    = is_start ? major : (steps_q - SW'(1));
		n_color    = is_start ? item.pen_color : color_q;
	end

	// clip, address split and bank switch detection
	logic                        vis;
	logic [AW-1:0]               addr;
	logic [lrbf_pkg::BANK_W-1:0] bk;
	logic [lrbf_pkg::OFFSET_W-1:0] off;
	logic                        sw;

	always_comb begin
		vis  = !nx[CW-1] && ($unsigned(nx) < WIDTH_LIM) &&
		       !ny[CW-1] && ($unsigned(ny) < HEIGHT_LIM);
		addr = {ny[RS-1:0], nx[RS-1:0]};
		bk   = lrbf_pkg::BANK_W'(addr >> BANK_SHIFT);
		off  = lrbf_pkg::OFFSET_W'(addr & OFF_MASK);
		sw   = vis && (!bank_known_q || (bk != last_bank_q));

		pix.pixel_x     = nx;
		pix.pixel_y     = ny;
		pix.visible     = vis;
		pix.bank        = vis ? bk : '0;
		pix.bank_offset = vis ? off : '0;
		pix.bank_switch = sw;
		pix.write_color = vis ? n_color : '0;
		pix.last_pixel  = n_steps == '0;
	end

	// state update when an item that gives a pixel goes through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q          <= '0;
			y_q          <= '0;
			dec_q        <= '0;
			minor2_q     <= '0;
			diag_q       <= '0;
			steps_q      <= '0;
			xdir_q       <= '0;
			ydir_q       <= '0;
			xmaj_q       <= 1'b0;
			color_q      <= '0;
			busy_q       <= 1'b0;
			last_bank_q  <= '0;
			bank_known_q <= 1'b0;
		end else if (fire && has_result) begin
			x_q     <= nx;
			y_q     <= ny;
			steps_q <= n_steps;
			busy_q  <= n_steps != '0;
			if (is_start) begin
				dec_q    <= st_dec;
				minor2_q <= {minor, 1'b0};
				diag_q   <= st_diag;
				xdir_q   <= st_xdir;
				ydir_q   <= st_ydir;
				xmaj_q   <= st_xmaj;
				color_q  <= item.pen_color;
			end else begin
				dec_q <= sp_dec;
			end
			if (vis) begin
				last_bank_q  <= bk;
				bank_known_q <= 1'b1;
			end
		end
	end

	`LRBF_NEVER(a_busy_steps, clk, arst_n, busy_q && (steps_q == '0))
	`LRBF_NEVER(a_dec_range, clk, arst_n, (dec_q > DEC_BOUND) || (dec_q < -DEC_BOUND))
	`LRBF_ASSERT(a_step_count, clk, arst_n, (fire && !is_start && busy_q) |=> (steps_q == ($past(steps_q) - SW'(1))))
	`LRBF_NEVER(a_switch_vis, clk, arst_n, fire && has_result && pix.bank_switch && !pix.visible)

endmodule

`default_nettype wire

// ----- verif/tb_line_raster_banked_fb_core.sv -----
// testbench for line_raster_banked_fb_core: drives start and step items, predicts every pixel
// with an internal bresenham walker and bank tracker, and checks results in order
// depends on lrbf_pkg and the rtl of line_raster_banked_fb_core

module tb_line_raster_banked_fb_core;

	localparam int SCR_W       = lrbf_pkg::DEF_SCREEN_WIDTH;
	localparam int SCR_H       = lrbf_pkg::DEF_SCREEN_HEIGHT;
	localparam int BANK_SH     = lrbf_pkg::DEF_BANK_SHIFT;
	localparam int HOLD_CYCLES = 200;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 10;
	localparam int PIXEL_GOAL  = 500;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// expected pixel store and line walker
	class pixel_scoreboard;
		lrbf_pkg::coord_t   pen_x, pen_y;
		logic signed [14:0] err_term;
		logic signed [13:0] minor_inc;
		logic signed [14:0] diag_inc;
		logic [12:0]        pixels_left;
		logic signed [1:0]  step_x, step_y;
		logic               walk_x;
		logic               drawing;
		logic [15:0]        color_reg;
		logic [4:0]         cur_bank;
		logic               bank_valid;
		lrbf_pkg::pixel_t   pixels_due[$];
		int                 mismatches;
		int                 checked;

		function new();
			pen_x = '0;
			pen_y = '0;
			err_term = '0;
			minor_inc = '0;
			diag_inc = '0;
			pixels_left = '0;
			step_x = '0;
			step_y = '0;
			walk_x = 1'b0;
			drawing = 1'b0;
			color_reg = '0;
			cur_bank = '0;
			bank_valid = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		function int pending();
			return pixels_due.size();
		endfunction

		// clip, address split and bank tracking for the current pen position
		function void push_pixel();
			lrbf_pkg::pixel_t p;
			int               addr;
			p = '0;
			p.pixel_x = pen_x;
			p.pixel_y = pen_y;
			p.visible = (pen_x >= 0) && (pen_x < SCR_W) && (pen_y >= 0) && (pen_y < SCR_H);
			if (p.visible) begin
				addr = (int'(pen_y) << lrbf_pkg::ROW_SHIFT) + int'(pen_x);
				p.bank = 5'(addr >> BANK_SH);
				p.bank_offset = 15'(addr & ((1 << BANK_SH) - 1));
				if (!bank_valid || p.bank != cur_bank) begin
					p.bank_switch = 1'b1;
					cur_bank = p.bank;
					bank_valid = 1'b1;
				end
				p.write_color = color_reg;
			end
			p.last_pixel = (pixels_left == 0);
			pixels_due.push_back(p);
		endfunction

		// returns 1 when the accepted item produces a pixel
		function bit note_item(lrbf_pkg::item_t it);
			int x1, y1, x2, y2, dx, dy, major, minor, d;
			if (it.op == lrbf_pkg::OP_START) begin
				x1 = it.x_start;
				y1 = it.y_start;
				x2 = it.x_end;
				y2 = it.y_end;
				dx = (x1 > x2) ? x1 - x2 : x2 - x1;
				dy = (y1 > y2) ? y1 - y2 : y2 - y1;
				color_reg = it.pen_color;
				if (x1 == x2) begin
					// vertical: walk up from the smaller y
					pen_x = lrbf_pkg::coord_t'(x1);
					pen_y = lrbf_pkg::coord_t'((y1 < y2) ? y1 : y2);
					step_x = 2'sd0;
					step_y = 2'sd1;
				end else if (y1 == y2) begin
					// horizontal: walk right from the smaller x
					pen_x = lrbf_pkg::coord_t'((x1 < x2) ? x1 : x2);
					pen_y = lrbf_pkg::coord_t'(y1);
					step_x = 2'sd1;
					step_y = 2'sd0;
				end else begin
					pen_x = lrbf_pkg::coord_t'(x1);
					pen_y = lrbf_pkg::coord_t'(y1);
					step_x = (x2 > x1) ? 2'sd1 : -2'sd1;
					step_y = (y2 > y1) ? 2'sd1 : -2'sd1;
				end
				walk_x = (dx >= dy);
				major = walk_x ? dx : dy;
				minor = walk_x ? dy : dx;
				minor_inc = 14'(2 * minor);
				err_term = 15'(2 * minor - major);
				diag_inc = 15'(2 * minor - 2 * major);
				pixels_left = 13'(major);
				drawing = (major != 0);
				push_pixel();
				return 1'b1;
			end
			// step with no line active is dropped
			if (!drawing)
				return 1'b0;
			d = err_term;
			if (d <= 0) begin
				d += minor_inc;
			end else begin
				d += diag_inc;
				if (walk_x)
					pen_y += step_y;
				else
					pen_x += step_x;
			end
			err_term = 15'(d);
			if (walk_x)
				pen_x += step_x;
			else
				pen_y += step_y;
			pixels_left -= 13'd1;
			if (pixels_left == 0)
				drawing = 1'b0;
			push_pixel();
			return 1'b1;
		endfunction

		// compare one result against the oldest expected pixel
		function void check_pixel(lrbf_pkg::pixel_t got);
			lrbf_pkg::pixel_t want;
			checked++;
			if (pixels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel #%0d: x=%0d y=%0d", checked, got.pixel_x,
						got.pixel_y);
				return;
			end
			want = pixels_due.pop_front();
			if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
					got.visible !== want.visible || got.bank !== want.bank ||
					got.bank_offset !== want.bank_offset ||
					got.bank_switch !== want.bank_switch ||
					got.write_color !== want.write_color ||
					got.last_pixel !== want.last_pixel) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("pixel #%0d differs", checked);
					$display("  exp x=%0d y=%0d vis=%b bank=%0d off=%0d sw=%b col=%h last=%b",
						want.pixel_x, want.pixel_y, want.visible, want.bank,
						want.bank_offset, want.bank_switch, want.write_color,
						want.last_pixel);
					$display("  got x=%0d y=%0d vis=%b bank=%0d off=%0d sw=%b col=%h last=%b",
						got.pixel_x, got.pixel_y, got.visible, got.bank,
						got.bank_offset, got.bank_switch, got.write_color,
						got.last_pixel);
				end
			end
		endfunction
	endclass

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic                                 op = 1'b0;
	lrbf_pkg::coord_t                     x_start = '0;
	lrbf_pkg::coord_t                     y_start = '0;
	lrbf_pkg::coord_t                     x_end = '0;
	lrbf_pkg::coord_t                     y_end = '0;
	logic [lrbf_pkg::COLOR_W-1:0]         pen_color = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	lrbf_pkg::coord_t                     pixel_x;
	lrbf_pkg::coord_t                     pixel_y;
	logic                                 visible;
	logic [lrbf_pkg::BANK_W-1:0]          bank;
	logic [lrbf_pkg::OFFSET_W-1:0]        bank_offset;
	logic                                 bank_switch;
	logic [lrbf_pkg::COLOR_W-1:0]         write_color;
	logic                                 last_pixel;

	pixel_scoreboard sb = new();

	int          pixels_sent;
	int          burst_left;
	int          hold_asks;
	int          hold_served;
	int          hold_left;
	int          mode_left;
	int          stall_phase;
	int          quiet_cycles;
	stall_mode_t stall_mode;

	line_raster_banked_fb_core dut (.*);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic lrbf_pkg::item_t start_item(int x1, int y1, int x2, int y2,
			logic [15:0] col);
		lrbf_pkg::item_t it;
		it.op = lrbf_pkg::OP_START;
		it.x_start = lrbf_pkg::coord_t'(x1);
		it.y_start = lrbf_pkg::coord_t'(y1);
		it.x_end = lrbf_pkg::coord_t'(x2);
		it.y_end = lrbf_pkg::coord_t'(y2);
		it.pen_color = col;
		return it;
	endfunction

	// step item; endpoint fields carry noise the block should ignore
	function automatic lrbf_pkg::item_t step_item();
		lrbf_pkg::item_t it;
		it.op = lrbf_pkg::OP_STEP;
		it.x_start = lrbf_pkg::coord_t'($urandom);
		it.y_start = lrbf_pkg::coord_t'($urandom);
		it.x_end = lrbf_pkg::coord_t'($urandom);
		it.y_end = lrbf_pkg::coord_t'($urandom);
		it.pen_color = 16'($urandom);
		return it;
	endfunction

	// offer one item until accepted, then maybe end the burst with a gap
	task automatic push_item(input lrbf_pkg::item_t it);
		in_valid <= 1'b1;
		op <= it.op;
		x_start <= it.x_start;
		y_start <= it.y_start;
		x_end <= it.x_end;
		y_end <= it.y_end;
		pen_color <= it.pen_color;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		pixels_sent += sb.note_item(it);
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// result side: check accepted pixels, then pick the next stall value
	always @(posedge clk) begin
		lrbf_pkg::pixel_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.pixel_x = pixel_x;
			got.pixel_y = pixel_y;
			got.visible = visible;
			got.bank = bank;
			got.bank_offset = bank_offset;
			got.bank_switch = bank_switch;
			got.write_color = write_color;
			got.last_pixel = last_pixel;
			sb.check_pixel(got);
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_asks != hold_served) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (mode_left <= 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			stall_phase++;
			case (stall_mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 6);
				STALL_PERIODIC: out_stall <= (stall_phase % 3 == 0);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus
	initial begin
		int  x1, y1, dx, dy, n, kind, major, shape;
		bit  held, drained;
		lrbf_pkg::item_t it;
		held = 1'b0;
		drained = 1'b0;
		burst_left = $urandom_range(1, 40);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle step, single points at the corners, clipped extremes
		push_item(step_item());
		push_item(start_item(0, 0, 0, 0, 16'hffff));
		push_item(step_item());
		push_item(start_item(SCR_W - 1, SCR_H - 1, SCR_W - 1, SCR_H - 1, 16'h0000));
		push_item(start_item(-2048, -2048, -2048, -2048, 16'ha5a5));
		push_item(start_item(2047, 2047, 2047, 2047, 16'h5a5a));
		// reversed horizontal line running off the right edge
		push_item(start_item(1025, 5, 1021, 5, 16'h1234));
		repeat (4) push_item(step_item());
		// reversed vertical line crossing into the next bank
		push_item(start_item(3, 33, 3, 30, 16'hf800));
		repeat (3) push_item(step_item());
		// steep line going down-left, abandoned by a new start
		push_item(start_item(5, 5, 3, 0, 16'h07e0));
		repeat (2) push_item(step_item());
		push_item(start_item(-1, 2, 1, 3, 16'h001f));
		repeat (2) push_item(step_item());
		// widest possible extents, cut short
		push_item(start_item(-2048, 2047, 2047, -2048, 16'hffff));
		push_item(step_item());

		// random lines, mostly well formed with small extents
		while (pixels_sent < PIXEL_GOAL) begin
			if (!held && pixels_sent >= 150) begin
				held = 1'b1;
				hold_asks++;
			end
			if (!drained && pixels_sent >= 320) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				do
					@(posedge clk);
				while (sb.pending() != 0);
			end
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				x1 = int'($urandom_range(0, 1103)) - 40;
				y1 = int'($urandom_range(0, 847)) - 40;
				dx = int'($urandom_range(0, 48)) - 24;
				dy = int'($urandom_range(0, 48)) - 24;
				shape = $urandom_range(0, 19);
				if (shape < 3)
					dx = 0;
				else if (shape < 6)
					dy = 0;
				else if (shape == 6) begin
					dx = 0;
					dy = 0;
				end
				major = (dx < 0) ? -dx : dx;
				if (((dy < 0) ? -dy : dy) > major)
					major = (dy < 0) ? -dy : dy;
				n = major;
				case ($urandom_range(0, 9))
					0:       n = $urandom_range(0, major);
					1:       n = major + $urandom_range(1, 2);
					default: n = major;
				endcase
				push_item(start_item(x1, y1, x1 + dx, y1 + dy, 16'($urandom)));
				repeat (n) push_item(step_item());
			end else if (kind < 85) begin
				it = start_item(int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048, 16'($urandom));
				push_item(it);
				repeat ($urandom_range(0, 6)) push_item(step_item());
			end else begin
				it = step_item();
				it.op = lrbf_pkg::op_t'($urandom_range(0, 1));
				push_item(it);
			end
		end

		// drain and report
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/lrbf_pkg.sv
rtl/lrbf_engine.sv
rtl/line_raster_banked_fb_core.sv
verif/tb_line_raster_banked_fb_core.sv
